// File: hdl/mse_pkg.sv
// Shared types and constants for the mean squared error loss and gradient block.
package mse_pkg;

    localparam int DATA_WIDTH   = 16;                 // Q8.8 input width
    localparam int MAX_ELEMENTS = 1024;               // longest vector
    localparam int COUNT_W      = 11;                 // element count / counter width
    localparam int MAG_W        = DATA_WIDTH;         // |actual - expected|
    localparam int GDIV_W       = MAG_W + 1;          // 2 * |diff|
    localparam int SQ_W         = 2 * MAG_W;          // squared difference
    localparam int SUM_W        = 42;                 // running square sum
    localparam int GRAD_W       = 18;                 // gradient output width
    localparam int LOSS_W       = 32;                 // loss output width
    localparam int STEP_W       = $clog2(SUM_W + 1);  // divider step counter
    localparam int FIFO_DEPTH   = 2;                  // front-to-back job queue
    localparam int IN_W         = 2 * DATA_WIDTH;     // input beat width
    localparam int OUT_W        = 56;                 // output beat width

    // One classified element handed from the front end to the divider.
    typedef struct packed {
        logic [GDIV_W-1:0]  grad_dividend;   // 2 * |diff|
        logic               grad_neg;        // diff below zero
        logic               last;            // element closes the vector
        logic [SUM_W-1:0]   sum;             // square sum including this element
        logic [COUNT_W-1:0] n;               // effective vector length
    } job_t;

endpackage

// File: hdl/mse_fifo.sv
// Small job queue between the front end and the divider back end.
module mse_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mse_pkg::job_t     push_data,
    output logic              full,
    input  logic              pop,
    output mse_pkg::job_t     pop_data,
    output logic              empty
);

    localparam int PTR_W = (mse_pkg::FIFO_DEPTH > 1) ? $clog2(mse_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(mse_pkg::FIFO_DEPTH + 1);

    mse_pkg::job_t    mem [mse_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(mse_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(mse_pkg::FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(mse_pkg::FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    // never written when full unless also read, never read when empty
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
        else $error("job queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("job queue underflow");
`endif

endmodule

// File: hdl/mse_front.sv
// Front end: config register, difference, square accumulation and vector tracking.
module mse_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [mse_pkg::COUNT_W-1:0]  cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mse_pkg::IN_W-1:0]     in_data,
    output logic                         push,
    output mse_pkg::job_t                push_data,
    input  logic                         full
);

    localparam int CW = mse_pkg::COUNT_W;
    localparam int DW = mse_pkg::DATA_WIDTH;

    logic [CW-1:0]                  element_count_reg;
    logic [CW-1:0]                  n_eff;
    logic                           hold_reg;
    logic [mse_pkg::MAG_W-1:0]      mag_reg;
    logic                           neg_reg;
    logic [mse_pkg::SUM_W-1:0]      sum_reg;
    logic [mse_pkg::SUM_W-1:0]      sum_next;
    logic [CW-1:0]                  cnt_reg;
    logic [CW-1:0]                  cnt_inc;
    logic                           last;
    logic signed [DW:0]             diff;
    logic [DW:0]                    diff_neg;
    logic [mse_pkg::SQ_W-1:0]       square;

    // zero means one, anything above the maximum is clamped
    always_comb
    begin
        n_eff = element_count_reg;
        if (element_count_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (element_count_reg > CW'(mse_pkg::MAX_ELEMENTS))
        begin
            n_eff = CW'(mse_pkg::MAX_ELEMENTS);
        end
    end

    assign diff     = $signed({in_data[2*DW-1], in_data[2*DW-1:DW]})
                    - $signed({in_data[DW-1], in_data[DW-1:0]});
    assign diff_neg = -diff;

    assign square   = mag_reg * mag_reg;
    assign sum_next = sum_reg + mse_pkg::SUM_W'(square);
    assign cnt_inc  = cnt_reg + CW'(1);
    assign last     = (cnt_inc >= n_eff);

    assign in_ready = !hold_reg;
    assign push     = hold_reg && !full;

    always_comb
    begin
        push_data.grad_dividend = {mag_reg, 1'b0};
        push_data.grad_neg      = neg_reg;
        push_data.last          = last;
        push_data.sum           = sum_next;
        push_data.n             = n_eff;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mag_reg <= diff[DW] ? diff_neg[DW-1:0] : diff[DW-1:0];
            neg_reg <= diff[DW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= CW'(1);
            hold_reg          <= 1'b0;
            sum_reg           <= '0;
            cnt_reg           <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                element_count_reg <= cfg_wr_data;
            end
            if (in_valid && in_ready)
            begin
                hold_reg <= 1'b1;
            end
            else if (push)
            begin
                hold_reg <= 1'b0;
            end
            if (push)
            begin
                sum_reg <= last ? '0 : sum_next;
                cnt_reg <= last ? '0 : cnt_inc;
            end
        end
    end

`ifndef SYNTHESIS
    // the vector always closes before the counter reaches the maximum length
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CW'(mse_pkg::MAX_ELEMENTS))
        else $error("element counter out of range");
`endif

endmodule

// File: hdl/mse_back.sv
// Back end: shared radix-2 divider for gradient and loss, output register.
module mse_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          empty,
    input  mse_pkg::job_t                 pop_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mse_pkg::GRAD_W-1:0]    out_gradient,
    output logic [mse_pkg::LOSS_W-1:0]    out_loss,
    output logic                          out_last
);

    localparam int CW = mse_pkg::COUNT_W;
    localparam int SW = mse_pkg::SUM_W;
    localparam int GW = mse_pkg::GDIV_W;
    localparam int TW = mse_pkg::STEP_W;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_GRAD = 4'b0010,
        B_LOSS = 4'b0100,
        B_DONE = 4'b1000
    } back_state_t;

    back_state_t             state_reg;
    back_state_t             state_next;
    logic [CW-1:0]           r_reg;
    logic [SW-1:0]           q_reg;
    logic [CW-1:0]           n_reg;
    logic [TW-1:0]           steps_reg;
    logic                    last_reg;
    logic                    neg_reg;
    logic [SW-1:0]           sum_reg;
    logic [GW-1:0]           grad_q_reg;
    logic [mse_pkg::LOSS_W-1:0] loss_q_reg;
    logic                    out_valid_reg;
    logic [mse_pkg::GRAD_W-1:0] out_gradient_reg;
    logic [mse_pkg::LOSS_W-1:0] out_loss_reg;
    logic                    out_last_reg;

    logic [CW:0]             rs;
    logic                    ge;
    logic [CW:0]             rs_sub;
    logic [CW-1:0]           r_step;
    logic [SW-1:0]           q_step;
    logic                    step_last;
    logic                    out_load;
    logic [mse_pkg::GRAD_W-1:0] grad_mag;

    // one quotient bit per cycle
    assign rs        = {r_reg, q_reg[SW-1]};
    assign ge        = (rs >= {1'b0, n_reg});
    assign rs_sub    = rs - {1'b0, n_reg};
    assign r_step    = ge ? rs_sub[CW-1:0] : rs[CW-1:0];
    assign q_step    = {q_reg[SW-2:0], ge};
    assign step_last = (steps_reg == TW'(1));

    assign pop      = (state_reg == B_IDLE) && !empty;
    assign out_load = (state_reg == B_DONE) && (!out_valid_reg || out_ready);
    assign grad_mag = {1'b0, grad_q_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = B_GRAD;
                end
            end
            B_GRAD:
            begin
                if (step_last)
                begin
                    state_next = last_reg ? B_LOSS : B_DONE;
                end
            end
            B_LOSS:
            begin
                if (step_last)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_load)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            r_reg     <= '0;
            q_reg     <= {pop_data.grad_dividend, (SW - GW)'(0)};
            n_reg     <= pop_data.n;
            steps_reg <= TW'(GW);
            last_reg  <= pop_data.last;
            neg_reg   <= pop_data.grad_neg;
            sum_reg   <= pop_data.sum;
        end
        else if (state_reg == B_GRAD && step_last)
        begin
            grad_q_reg <= q_step[GW-1:0];
            r_reg      <= '0;
            q_reg      <= sum_reg;
            steps_reg  <= TW'(SW);
        end
        else if (state_reg == B_GRAD || state_reg == B_LOSS)
        begin
            r_reg     <= r_step;
            q_reg     <= q_step;
            steps_reg <= steps_reg - TW'(1);
            if (state_reg == B_LOSS && step_last)
            begin
                loss_q_reg <= q_step[mse_pkg::LOSS_W-1:0];
            end
        end
        if (out_load)
        begin
            out_gradient_reg <= neg_reg ? -grad_mag : grad_mag;
            out_loss_reg     <= last_reg ? loss_q_reg : '0;
            out_last_reg     <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_gradient = out_gradient_reg;
    assign out_loss     = out_loss_reg;
    assign out_last     = out_last_reg;

`ifndef SYNTHESIS
    // partial remainder stays below the divisor while dividing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_GRAD || state_reg == B_LOSS) |-> (r_reg < n_reg))
        else $error("divider remainder not below divisor");
    // step counter is live while dividing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_GRAD || state_reg == B_LOSS) |-> (steps_reg != '0))
        else $error("divider step count exhausted");
    // loss field only carries a value on the closing beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (out_loss_reg == '0))
        else $error("loss set on a non-closing beat");
`endif

endmodule

// File: hdl/mse_loss_and_gradient.sv
// Top level of the mean squared error loss and gradient block.
//
// Input channel s_axis_*: one beat per element, expected and actual value in
// signed Q8.8. Output channel m_axis_*: one beat per input beat, in order,
// carrying the gradient 2*(actual-expected)/n (Q8.8, truncated toward zero)
// and, on the beat that closes a vector (m_axis_tlast high), the mean squared
// error sum/n in Q16.16. On other beats the loss field is zero.
// cfg_wr_en/cfg_wr_data set the vector length n (0 acts as 1, values above
// 1024 act as 1024); write it only while the block is idle.
// Throughput: the front end holds each element until it is queued before
// taking the next; the back end's shared one-bit-per-cycle divider limits
// the rate (a load step, 17 gradient quotient bits and an output step per
// element, plus 42 loss quotient bits on the closing element). Each input
// beat passes the front-end register, the queue, the divider and output register.
// A two-entry queue decouples front and back; a stalled receiver holds the
// output register, then the queue fills and s_axis_tready drops.
// Reset clears the running sum, the element counter and all valid flags,
// and sets n to 1.
module mse_loss_and_gradient
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [mse_pkg::COUNT_W-1:0]  cfg_wr_data,     // element_count
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [mse_pkg::IN_W-1:0]     s_axis_tdata,    // expected_value, actual_value
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [mse_pkg::OUT_W-1:0]    m_axis_tdata,    // gradient, loss, zero pad
    output logic                         m_axis_tlast     // loss_valid
);

    mse_pkg::job_t                push_data;
    mse_pkg::job_t                pop_data;
    logic                         push;
    logic                         pop;
    logic                         full;
    logic                         empty;
    logic [mse_pkg::GRAD_W-1:0]   gradient;
    logic [mse_pkg::LOSS_W-1:0]   loss;

    // difference, square sum, vector position
    mse_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_data     (s_axis_tdata),
        .push        (push),
        .push_data   (push_data),
        .full        (full)
    );

    mse_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // divider and output register
    mse_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_gradient (gradient),
        .out_loss     (loss),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {(mse_pkg::OUT_W - mse_pkg::LOSS_W - mse_pkg::GRAD_W)'(0),
                           loss, gradient};

endmodule

// File: bench/mse_loss_and_gradient_tb.sv
// Self-checking bench for the MSE loss and gradient block: random stream traffic, inline predictor.
module mse_loss_and_gradient_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_WIDTH   = mse_pkg::DATA_WIDTH;
    localparam int MAX_ELEMENTS = mse_pkg::MAX_ELEMENTS;
    localparam int COUNT_W      = mse_pkg::COUNT_W;
    localparam int SUM_W        = mse_pkg::SUM_W;
    localparam int GRAD_W       = mse_pkg::GRAD_W;
    localparam int LOSS_W       = mse_pkg::LOSS_W;
    localparam int IN_W         = mse_pkg::IN_W;
    localparam int OUT_W        = mse_pkg::OUT_W;

    localparam int CYCLE_LIMIT  = 600_000;  // generous; slowest clean run is well under this
    localparam int DRAIN_CYCLES = 70;       // covers the closing element's path from input to output
    localparam int IDLE_PCT     = 8;

    // One input element (expected, actual), both signed Q8.8.
    typedef struct {
        logic signed [DATA_WIDTH-1:0] expected_value;
        logic signed [DATA_WIDTH-1:0] actual_value;
    } element_t;

    // One output beat as the predictor sees it.
    typedef struct {
        logic signed [GRAD_W-1:0] gradient;
        logic [LOSS_W-1:0]        loss;
        logic                     loss_valid;
    } grad_loss_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [COUNT_W-1:0]   cfg_wr_data   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;   // expected_value [15:0], actual_value [31:16]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;         // gradient [17:0], loss [49:18], zero pad
    logic                 m_axis_tlast;         // loss_valid

    // Stimulus waiting for the driver, and beats the block still owes us.
    element_t   element_q[$];
    grad_loss_t grad_loss_q[$];

    // Predictor copy of the block's register and accumulator state.
    logic [COUNT_W-1:0] length_reg;
    logic [SUM_W-1:0]   sq_sum;
    int                 elems_seen;

    // Idle knobs, steered by the stimulus process.
    int  tx_idle_pct = IDLE_PCT;
    int  rx_idle_pct = IDLE_PCT;
    bit  tx_hold     = 1'b0;

    int  error_count = 0;
    int  cycle_count = 0;

    mse_loss_and_gradient dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: one accepted element -> one expected output beat.
    // Zero length acts as one, anything past MAX_ELEMENTS clamps. The vector
    // closes once the element count reaches n, even if it already passed n
    // (length shrunk mid-vector).
    // ------------------------------------------------------------------
    function automatic void predict_grad_loss(input element_t e);
        longint     diff;
        longint     n;
        longint     mag;
        longint     grad;
        grad_loss_t r;
        diff = longint'(e.actual_value) - longint'(e.expected_value);
        if (length_reg == 0)
            n = 1;
        else if (length_reg > MAX_ELEMENTS)
            n = MAX_ELEMENTS;
        else
            n = longint'(length_reg);
        grad = (2 * diff) / n;              // SV division truncates toward zero
        mag  = (diff < 0) ? -diff : diff;
        r.gradient   = grad[GRAD_W-1:0];
        r.loss       = '0;
        r.loss_valid = 1'b0;
        sq_sum = SUM_W'(sq_sum + mag * mag);    // wraps at SUM_W
        elems_seen++;
        if (elems_seen >= n)
        begin
            r.loss       = LOSS_W'(sq_sum / n);
            r.loss_valid = 1'b1;
            sq_sum       = '0;
            elems_seen   = 0;
        end
        grad_loss_q.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: predicts on each accepted beat, then presents the next
    // element unless idling or held. tvalid gets at most one NBA per edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_elements
        element_t e;
        bit       free;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            free = !s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                e.expected_value = s_axis_tdata[DATA_WIDTH-1:0];
                e.actual_value   = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
                predict_grad_loss(e);
                free = 1'b1;
            end
            if (free)
            begin
                if (element_q.size() != 0 && !tx_hold
                    && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    e = element_q.pop_front();
                    s_axis_tdata  <= {e.actual_value, e.expected_value};
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure, compare each accepted beat with the
    // oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_results
        grad_loss_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (grad_loss_q.size() == 0)
                    report_mismatch("unexpected beat, gradient",
                                    $signed(m_axis_tdata[GRAD_W-1:0]), 0);
                else
                begin
                    want = grad_loss_q.pop_front();
                    if (m_axis_tdata[GRAD_W-1:0] !== want.gradient)
                        report_mismatch("gradient", $signed(m_axis_tdata[GRAD_W-1:0]),
                                        want.gradient);
                    if (m_axis_tdata[GRAD_W+LOSS_W-1:GRAD_W] !== want.loss)
                        report_mismatch("loss", m_axis_tdata[GRAD_W+LOSS_W-1:GRAD_W],
                                        want.loss);
                    if (m_axis_tlast !== want.loss_valid)
                        report_mismatch("tlast", m_axis_tlast, want.loss_valid);
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly full-range noise, some corner values, some small differences.
    function automatic element_t random_element();
        element_t e;
        logic signed [DATA_WIDTH-1:0] corners[5];
        corners = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001};
        case ($urandom_range(0, 19))
            0, 1, 2:
            begin
                e.expected_value = corners[$urandom_range(0, 4)];
                e.actual_value   = corners[$urandom_range(0, 4)];
            end
            3, 4, 5:
            begin
                e.expected_value = DATA_WIDTH'($urandom);
                e.actual_value   = DATA_WIDTH'(int'(e.expected_value)
                                               + int'($urandom_range(0, 8)) - 4);
            end
            default:
            begin
                e.expected_value = DATA_WIDTH'($urandom);
                e.actual_value   = DATA_WIDTH'($urandom);
            end
        endcase
        return e;
    endfunction

    task automatic push_pair(input int expected_value, input int actual_value);
        element_t e;
        e.expected_value = DATA_WIDTH'(expected_value);
        e.actual_value   = DATA_WIDTH'(actual_value);
        element_q.push_back(e);
    endtask

    // Block is idle: nothing queued, nothing presented, nothing owed.
    task automatic wait_idle();
        @(posedge clk);
        while (element_q.size() != 0 || s_axis_tvalid || grad_loss_q.size() != 0)
            @(posedge clk);
    endtask

    // Register writes only after a full drain plus the closing-element latency.
    task automatic set_length(input int value);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= COUNT_W'(value);
        length_reg   = COUNT_W'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : run_test
        int n;
        int len;
        int vectors;
        length_reg = COUNT_W'(1);   // register reset value
        sq_sum     = '0;
        elems_seen = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset length of one: every beat closes a vector. Full-scale
        // differences give the largest gradient magnitude and largest loss.
        push_pair(-32768, 32767);
        push_pair(32767, -32768);
        push_pair(0, 0);
        push_pair(5, 5);
        push_pair(0, 1);
        push_pair(1, 0);
        push_pair(-1, 0);

        // Zero length behaves as one.
        set_length(0);
        push_pair(100, -100);
        push_pair(0, -1);

        // n = 3: truncation toward zero on both signs.
        set_length(3);
        push_pair(0, 1);
        push_pair(0, -1);
        push_pair(0, 2);
        push_pair(2, 0);
        push_pair(-7, 9);   // two left open across the next write

        // Shrink mid-vector: next element closes with the count already past n.
        set_length(1);
        push_pair(7, 3);

        // Top of the register range clamps to MAX_ELEMENTS; all full-scale
        // differences push the sum and the loss to their ceilings.
        set_length((1 << COUNT_W) - 1);
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            if ($urandom_range(0, 1))
                push_pair(-32768, 32767);
            else
                push_pair(32767, -32768);
        end

        // Exactly MAX_ELEMENTS, partly filled, then shrunk to two.
        set_length(MAX_ELEMENTS);
        repeat (3) element_q.push_back(random_element());
        set_length(2);
        push_pair(-32768, -32768);

        // Random phases: a fresh length each time, whole vectors mostly,
        // sometimes a tail left open into the next phase.
        for (int phase = 0; phase < 14; phase++)
        begin
            case ($urandom_range(0, 9))
                0:       n = 0;
                1:       n = 1;
                2:       n = $urandom_range(MAX_ELEMENTS, (1 << COUNT_W) - 1);
                9:       n = $urandom_range(17, 100);
                default: n = $urandom_range(2, 16);
            endcase
            set_length(n);
            // long quiet stretch: no idling on either side
            tx_idle_pct = (phase == 6) ? 0 : IDLE_PCT;
            rx_idle_pct = (phase == 6) ? 0 : IDLE_PCT;
            vectors = 0;
            for (int sent = 0; sent < 60; sent += len)
            begin
                if (n <= 1)
                    len = 1;
                else if (n > 100 || $urandom_range(0, 7) == 0)
                    len = $urandom_range(1, 20);    // partial vector
                else
                    len = n;
                for (int k = 0; k < len; k++)
                    element_q.push_back(random_element());
                vectors++;
                while (element_q.size() > 4)
                    @(posedge clk);
                // sender stops until the block has handed back everything
                if (vectors % 9 == 4)
                begin
                    tx_hold = 1'b1;
                    @(posedge clk);
                    while (s_axis_tvalid || grad_loss_q.size() != 0)
                        @(posedge clk);
                    tx_hold = 1'b0;
                end
            end
        end
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (grad_loss_q.size() != 0)
            report_mismatch("beats still owed at end", grad_loss_q.size(), 0);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
